// File: hdl/pps_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the binary PPM stream parser.
package pps_pkg;

    localparam int DIM_W       = 17;
    localparam int NUM_EXT_W   = DIM_W + 4;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int PHASE_W     = 4;
    localparam int CHAN_W      = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * DIM_W + BYTE_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic [DIM_W-1:0] MAX_DIMENSION = DIM_W'(100000);
    localparam logic [DIM_W-1:0] MAXVAL_OK     = DIM_W'(255);

    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_HEADER  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PAYLOAD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FORMAT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MAXVAL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd4;

    localparam logic [PHASE_W-1:0] PH_MAGIC_P = 4'd0;
    localparam logic [PHASE_W-1:0] PH_MAGIC_6 = 4'd1;
    localparam logic [PHASE_W-1:0] PH_SKIP_W  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_CMT_W   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DIG_W   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SKIP_H  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CMT_H   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DIG_H   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SKIP_M  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CMT_M   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_DIG_M   = 4'd10;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd11;
    localparam logic [PHASE_W-1:0] PH_DONE    = 4'd12;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              end_mark;
        logic              is_space;
        logic              is_digit;
        logic              is_hash;
        logic              is_lf;
        logic              is_p;
        logic              is_six;
        logic [3:0]        digit;
    } t_token;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic [BYTE_W-1:0]   payload_byte;
        logic                last_byte;
    } t_result;

endpackage

// File: hdl/pps_front.sv
`timescale 1ns / 1ps
// Front stage: accepts input beats and classifies each byte into a token.
module pps_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] stream_byte
    input  logic                              s_axis_tuser,   // [0] end_mark
    output logic                              o_tok_valid,
    input  logic                              i_tok_ready,
    output pps_pkg::t_token                   o_tok
);

    logic            r_valid;
    pps_pkg::t_token r_tok;
    pps_pkg::t_token n_tok;
    logic [pps_pkg::BYTE_W-1:0] c;

    assign c = s_axis_tdata[pps_pkg::BYTE_W-1:0];

    always_comb begin
        n_tok          = '0;
        n_tok.data     = c;
        n_tok.end_mark = s_axis_tuser;
        n_tok.is_space = (c == pps_pkg::CH_SPACE) ||
                         ((c >= pps_pkg::CH_TAB) && (c <= pps_pkg::CH_CR));
        n_tok.is_digit = (c >= pps_pkg::CH_ZERO) && (c <= pps_pkg::CH_NINE);
        n_tok.is_hash  = (c == pps_pkg::CH_HASH);
        n_tok.is_lf    = (c == pps_pkg::CH_LF);
        n_tok.is_p     = (c == pps_pkg::CH_P);
        n_tok.is_six   = (c == pps_pkg::CH_SIX);
        n_tok.digit    = 4'(c - pps_pkg::CH_ZERO);
    end

    assign s_axis_tready = !r_valid || i_tok_ready;
    assign o_tok_valid   = r_valid;
    assign o_tok         = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_tok <= n_tok;
        end
    end

endmodule

// File: hdl/pps_queue.sv
`timescale 1ns / 1ps
// Short token queue between the front and back stages.
module pps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  pps_pkg::t_token i_push_tok,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output pps_pkg::t_token o_pop_tok
);

    pps_pkg::t_token                  r_mem [pps_pkg::QUEUE_DEPTH];
    logic [pps_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [pps_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [pps_pkg::QUEUE_CNT_W-1:0]  r_count;
    logic                             push;
    logic                             pop;

    assign o_push_ready = (r_count != pps_pkg::QUEUE_CNT_W'(pps_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_tok    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == pps_pkg::QUEUE_PTR_W'(pps_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == pps_pkg::QUEUE_PTR_W'(pps_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

endmodule

// File: hdl/pps_back.sv
`timescale 1ns / 1ps
// Back stage: header state machine, payload counters and the output register.
module pps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    output logic            o_tok_ready,
    input  pps_pkg::t_token i_tok,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output pps_pkg::t_result o_res
);

    logic [pps_pkg::PHASE_W-1:0] r_phase,  n_phase;
    logic [pps_pkg::DIM_W-1:0]   r_num,    n_num;
    logic [pps_pkg::DIM_W-1:0]   r_width,  n_width;
    logic [pps_pkg::DIM_W-1:0]   r_height, n_height;
    logic [pps_pkg::CHAN_W-1:0]  r_chan,   n_chan;
    logic [pps_pkg::DIM_W-1:0]   r_col,    n_col;
    logic [pps_pkg::DIM_W-1:0]   r_row,    n_row;
    logic                        r_out_valid;
    pps_pkg::t_result            r_out;
    pps_pkg::t_result            n_out;
    logic                        n_emit;
    logic                        consume;

    logic [pps_pkg::NUM_EXT_W-1:0] num_next;
    logic                          num_over;
    logic                          first_over;
    logic                          last_ch;
    logic                          last_col;
    logic                          last_row;
    logic                          is_last;
    logic                          is_skip;
    logic                          is_cmt;
    logic                          is_dig;
    logic [pps_pkg::PHASE_W-1:0]   ph_skip;
    logic [pps_pkg::PHASE_W-1:0]   ph_cmt;
    logic [pps_pkg::PHASE_W-1:0]   ph_dig;

    assign o_tok_ready = !r_out_valid || i_res_ready;
    assign consume     = i_tok_valid && o_tok_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign num_next = (pps_pkg::NUM_EXT_W'(r_num) << 3) + (pps_pkg::NUM_EXT_W'(r_num) << 1)
                    + pps_pkg::NUM_EXT_W'(i_tok.digit);
    assign num_over   = num_next > pps_pkg::NUM_EXT_W'(pps_pkg::MAX_DIMENSION);
    assign first_over = pps_pkg::DIM_W'(i_tok.digit) > pps_pkg::MAX_DIMENSION;

    assign last_ch  = (r_chan >= pps_pkg::CHAN_W'(2));
    assign last_col = ({1'b0, r_col} + 1'b1) >= {1'b0, r_width};
    assign last_row = ({1'b0, r_row} + 1'b1) >= {1'b0, r_height};
    assign is_last  = last_ch && last_col && last_row;

    always_comb begin
        is_skip = 1'b0;
        is_cmt  = 1'b0;
        is_dig  = 1'b0;
        ph_skip = pps_pkg::PH_SKIP_W;
        ph_cmt  = pps_pkg::PH_CMT_W;
        ph_dig  = pps_pkg::PH_DIG_W;
        case (r_phase)
            pps_pkg::PH_SKIP_W, pps_pkg::PH_CMT_W, pps_pkg::PH_DIG_W: begin
                ph_skip = pps_pkg::PH_SKIP_W;
                ph_cmt  = pps_pkg::PH_CMT_W;
                ph_dig  = pps_pkg::PH_DIG_W;
            end
            pps_pkg::PH_SKIP_H, pps_pkg::PH_CMT_H, pps_pkg::PH_DIG_H: begin
                ph_skip = pps_pkg::PH_SKIP_H;
                ph_cmt  = pps_pkg::PH_CMT_H;
                ph_dig  = pps_pkg::PH_DIG_H;
            end
            pps_pkg::PH_SKIP_M, pps_pkg::PH_CMT_M, pps_pkg::PH_DIG_M: begin
                ph_skip = pps_pkg::PH_SKIP_M;
                ph_cmt  = pps_pkg::PH_CMT_M;
                ph_dig  = pps_pkg::PH_DIG_M;
            end
            default: begin
            end
        endcase
        is_skip = (r_phase == pps_pkg::PH_SKIP_W) || (r_phase == pps_pkg::PH_SKIP_H) ||
                  (r_phase == pps_pkg::PH_SKIP_M);
        is_cmt  = (r_phase == pps_pkg::PH_CMT_W) || (r_phase == pps_pkg::PH_CMT_H) ||
                  (r_phase == pps_pkg::PH_CMT_M);
        is_dig  = (r_phase == pps_pkg::PH_DIG_W) || (r_phase == pps_pkg::PH_DIG_H) ||
                  (r_phase == pps_pkg::PH_DIG_M);
    end

    always_comb begin
        logic do_fail;
        logic do_clear;
        logic [pps_pkg::STATUS_W-1:0] fail_status;

        do_fail     = 1'b0;
        do_clear    = 1'b0;
        fail_status = pps_pkg::ST_FORMAT;
        n_phase  = r_phase;
        n_num    = r_num;
        n_width  = r_width;
        n_height = r_height;
        n_chan   = r_chan;
        n_col    = r_col;
        n_row    = r_row;
        n_emit   = 1'b0;
        n_out    = '0;

        if (i_tok.end_mark) begin
            if (r_phase == pps_pkg::PH_DONE) begin
                do_clear = 1'b1;
            end else if (r_phase == pps_pkg::PH_PAYLOAD) begin
                do_fail     = 1'b1;
                fail_status = pps_pkg::ST_TRUNC;
            end else begin
                do_fail = 1'b1;
            end
        end else if (r_phase == pps_pkg::PH_MAGIC_P) begin
            if (i_tok.is_p) begin
                n_phase = pps_pkg::PH_MAGIC_6;
            end else begin
                do_fail = 1'b1;
            end
        end else if (r_phase == pps_pkg::PH_MAGIC_6) begin
            if (i_tok.is_six) begin
                n_phase = pps_pkg::PH_SKIP_W;
            end else begin
                do_fail = 1'b1;
            end
        end else if (is_skip) begin
            if (i_tok.is_space) begin
                n_phase = r_phase;
            end else if (i_tok.is_hash) begin
                n_phase = ph_cmt;
            end else if (!i_tok.is_digit || first_over) begin
                do_fail = 1'b1;
            end else begin
                n_num   = pps_pkg::DIM_W'(i_tok.digit);
                n_phase = ph_dig;
            end
        end else if (is_cmt) begin
            if (i_tok.is_lf) begin
                n_phase = ph_skip;
            end
        end else if (is_dig) begin
            if (i_tok.is_digit) begin
                if (num_over) begin
                    do_fail = 1'b1;
                end else begin
                    n_num = num_next[pps_pkg::DIM_W-1:0];
                end
            end else if (!i_tok.is_space) begin
                do_fail = 1'b1;
            end else if (r_phase == pps_pkg::PH_DIG_W) begin
                n_width = r_num;
                n_num   = '0;
                n_phase = pps_pkg::PH_SKIP_H;
            end else if (r_phase == pps_pkg::PH_DIG_H) begin
                n_height = r_num;
                n_num    = '0;
                n_phase  = pps_pkg::PH_SKIP_M;
            end else if ((r_width == '0) || (r_height == '0)) begin
                do_fail = 1'b1;
            end else if (r_num != pps_pkg::MAXVAL_OK) begin
                do_fail     = 1'b1;
                fail_status = pps_pkg::ST_MAXVAL;
            end else begin
                n_num    = '0;
                n_chan   = '0;
                n_col    = '0;
                n_row    = '0;
                n_phase  = pps_pkg::PH_PAYLOAD;
                n_emit   = 1'b1;
                n_out.status       = pps_pkg::ST_HEADER;
                n_out.image_width  = r_width;
                n_out.image_height = r_height;
            end
        end else if (r_phase == pps_pkg::PH_PAYLOAD) begin
            if (is_last) begin
                n_phase = pps_pkg::PH_DONE;
            end else if (!last_ch) begin
                n_chan = r_chan + 1'b1;
            end else begin
                n_chan = '0;
                if (!last_col) begin
                    n_col = r_col + 1'b1;
                end else begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end
            end
            n_emit             = 1'b1;
            n_out.status       = pps_pkg::ST_PAYLOAD;
            n_out.payload_byte = i_tok.data;
            n_out.last_byte    = is_last;
        end else if (r_phase != pps_pkg::PH_DONE) begin
            do_clear = 1'b1;
        end

        if (do_fail) begin
            do_clear     = 1'b1;
            n_emit       = 1'b1;
            n_out        = '0;
            n_out.status = fail_status;
        end
        if (do_clear) begin
            n_phase  = pps_pkg::PH_MAGIC_P;
            n_num    = '0;
            n_width  = '0;
            n_height = '0;
            n_chan   = '0;
            n_col    = '0;
            n_row    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pps_pkg::PH_MAGIC_P;
            r_num       <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_chan      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (consume) begin
                r_phase  <= n_phase;
                r_num    <= n_num;
                r_width  <= n_width;
                r_height <= n_height;
                r_chan   <= n_chan;
                r_col    <= n_col;
                r_row    <= n_row;
            end
            if (consume) begin
                r_out_valid <= n_emit;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && n_emit) begin
            r_out <= n_out;
        end
    end

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan != 2'd3)
        else $error("Channel counter left its range.");

    a_payload_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pps_pkg::PH_PAYLOAD) |-> ((r_width != '0) && (r_height != '0)))
        else $error("Payload phase entered with a zero dimension.");

    a_header_to_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && n_emit && (n_out.status == pps_pkg::ST_HEADER))
        |=> (r_phase == pps_pkg::PH_PAYLOAD))
        else $error("Header beat did not start the payload.");

    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && n_emit && n_out.last_byte) |=> (r_phase == pps_pkg::PH_DONE))
        else $error("Last payload byte did not finish the image.");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=> r_out_valid)
        else $error("A stalled result was dropped.");

endmodule

// File: hdl/ppm_p6_stream_parser_core.sv
`timescale 1ns / 1ps
// Top level of the binary PPM (P6) header parser and payload passer.
//
// The input channel carries one file byte per beat in s_axis_tdata, or an
// end-of-stream mark in s_axis_tuser with no byte. The output channel gives
// at most one beat per input beat: a header beat with width and height once
// the header is complete, one beat per RGB sample byte with tlast on the
// final sample, or an error beat (format error, unsupported maxval or
// truncated stream). Whitespace, comments, magic bytes, trailing bytes and
// an end mark after a complete image give no beat.
// One beat is taken every cycle while s_axis_tready is high. A byte passes a
// classifying register, a two-entry queue and the output register before
// its result is shown on m_axis_tvalid and can be taken by the receiver.
// After reset, and after every error or end of stream, the parser waits for
// the magic bytes again. When the receiver holds tready low, the output
// register keeps its beat, the queue and the front register fill, and then
// s_axis_tready drops; no beat is lost.
module ppm_p6_stream_parser_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] stream_byte
    input  logic                               s_axis_tuser,  // [0] end_mark
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [16:0] image_width, [33:17] image_height, [41:34] payload_byte, [47:42] zero
    output logic [pps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [pps_pkg::STATUS_W-1:0]       m_axis_tuser,  // [2:0] status
    output logic                               m_axis_tlast   // last_byte
);

    logic             front_valid;
    logic             front_ready;
    pps_pkg::t_token  front_tok;
    logic             back_valid;
    logic             back_ready;
    pps_pkg::t_token  back_tok;
    pps_pkg::t_result res;

    pps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_tok_valid   (front_valid),
        .i_tok_ready   (front_ready),
        .o_tok         (front_tok)
    );

    pps_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_tok   (front_tok),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_tok    (back_tok)
    );

    pps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (back_valid),
        .o_tok_ready (back_ready),
        .i_tok       (back_tok),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {{pps_pkg::OUT_PAD_W{1'b0}}, res.payload_byte,
                           res.image_height, res.image_width};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last_byte;

endmodule
